>>> design/ccfr_pkg.sv
// Shared constants, types and controller/datapath interface structs for the
// colon/CR-LF frame receiver. No dependencies.
`default_nettype none

package ccfr_pkg;

  localparam int MAX_PAYLOAD = 8;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 2);
  localparam int IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  localparam int BYTE_W      = 8;
  localparam int POS_W       = 3;
  localparam int LEN_W       = 4;
  localparam int OUT_DATA_W  = 16;

  localparam logic [BYTE_W-1:0] CH_START = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECV,
    ST_WAIT_LF,
    ST_EMIT
  } fsm_t;

  typedef struct packed {
    logic store_wr;
    logic cnt_inc;
    logic cnt_clr;
    logic idx_clr;
    logic idx_inc;
    logic emit_load;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic is_cr;
    logic is_lf;
    logic cnt_lt_max;
    logic cnt_eq_max;
    logic idx_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> design/ccfr_dp.sv
// Datapath: payload store, byte count, emit index and output word register.
// Depends on ccfr_pkg.
`default_nettype none

module ccfr_dp (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire  [ccfr_pkg::BYTE_W-1:0]   in_byte,
  input  wire  ccfr_pkg::cmd_t          cmd,
  output ccfr_pkg::sts_t                sts,
  output logic                          out_tvalid,
  input  wire                           out_tready,
  output logic [ccfr_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);
  import ccfr_pkg::*;

  logic [BYTE_W-1:0] store_r [MAX_PAYLOAD];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] byte_r;
  logic [POS_W-1:0]  pos_r;
  logic [LEN_W-1:0]  len_r;
  logic              last_r;

  always_comb begin
    sts.is_start   = (in_byte == CH_START);
    sts.is_cr      = (in_byte == CH_CR);
    sts.is_lf      = (in_byte == CH_LF);
    sts.cnt_lt_max = (cnt_r < CNT_W'(MAX_PAYLOAD));
    sts.cnt_eq_max = (cnt_r == CNT_W'(MAX_PAYLOAD));
    sts.idx_last   = (cnt_r == '0) || ((CNT_W'(idx_r) + CNT_W'(1)) == cnt_r);
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_comb begin
    priority if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
    priority if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end else begin
      idx_nxt = idx_r;
    end
    priority if (cmd.emit_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_wr) begin
      store_r[cnt_r[IDX_W-1:0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      byte_r <= (cnt_r == '0) ? '0 : store_r[idx_r];
      pos_r  <= POS_W'(idx_r);
      len_r  <= LEN_W'(cnt_r);
      last_r <= sts.idx_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - BYTE_W - POS_W - LEN_W){1'b0}}, len_r, pos_r, byte_r};
  assign out_tlast  = last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PAYLOAD + 1))
    else $error("byte count beyond limit");

  a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_wr |-> sts.cnt_lt_max)
    else $error("store write past end");

  a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> (cnt_r == '0 || CNT_W'(idx_r) < cnt_r))
    else $error("emit index beyond frame");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_load |-> sts.out_free)
    else $error("output word overwritten");

endmodule

`default_nettype wire

>>> design/ccfr_ctrl.sv
// Controller: frame phase state machine driving the datapath commands.
// Depends on ccfr_pkg.
`default_nettype none

module ccfr_ctrl (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  input  wire  ccfr_pkg::sts_t  sts,
  output ccfr_pkg::cmd_t        cmd
);
  import ccfr_pkg::*;

  fsm_t state_r, state_nxt;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    in_tready = (state_r != ST_EMIT);
    accept    = in_tvalid && in_tready;
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && sts.is_start) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = ST_RECV;
        end
      end
      ST_RECV: begin
        if (accept) begin
          if (sts.is_cr) begin
            state_nxt = ST_WAIT_LF;
          end else begin
            cmd.store_wr = sts.cnt_lt_max;
            cmd.cnt_clr  = sts.is_start;
            cmd.cnt_inc  = !sts.is_start;
            if (!sts.is_start && (sts.cnt_eq_max || sts.is_lf)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_WAIT_LF: begin
        if (accept) begin
          priority if (sts.is_start) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_RECV;
          end else if (sts.is_lf) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = ST_EMIT;
          end else begin
            state_nxt   = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_load = 1'b1;
          if (sts.idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

>>> design/colon_crlf_frame_receiver_core.sv
// Frame receiver: one byte word per cycle outside emission; CR LF after a ':' frame emits
// the payload as a word run, one word per cycle while the output accepts.
// The closing LF moves the controller to its emit state, which loads the output
// word register once the output is free; the input is held during emission, one
// stored byte read per output word through the single store read port.
// Reset: synchronous active-low rst_n clears phase, count and output valid.
// Depends on ccfr_pkg, ccfr_ctrl, ccfr_dp.
`default_nettype none

module colon_crlf_frame_receiver_core (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  input  wire  [ccfr_pkg::BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  output logic                            out_tvalid,
  input  wire                             out_tready,
  output logic [ccfr_pkg::OUT_DATA_W-1:0] out_tdata,  // [7:0] frame_byte,
                                                      // [10:8] byte_position,
                                                      // [14:11] frame_length
  output logic                            out_tlast
);
  import ccfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ccfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccfr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

>>> verif/colon_crlf_frame_receiver_core_tb.sv
// Testbench for colon_crlf_frame_receiver_core: feeds ':'/CR/LF framed byte
// streams with random sender gaps and receiver stalls, and checks every
// emitted payload word against a cycle-free frame tracker. Depends on ccfr_pkg.
`default_nettype none

module colon_crlf_frame_receiver_core_tb;
  import ccfr_pkg::*;

  localparam int POS_LO = BYTE_W;
  localparam int LEN_LO = BYTE_W + POS_W;
  localparam int PAD_LO = BYTE_W + POS_W + LEN_W;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic [POS_W-1:0]  byte_pos;
    logic [LEN_W-1:0]  frame_len;
    logic              last;
  } frame_word_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  fsm_t              rx_state;
  logic [LEN_W-1:0]  rx_count;
  logic [BYTE_W-1:0] payload_mem [MAX_PAYLOAD];
  frame_word_t       frame_words_due [$];

  int        err_count = 0;
  int        burst_left = 0;
  int        gap_max = 6;
  int        hold_cycles = 0;
  int        rx_items = 0;
  logic [7:0] ready_pat;

  colon_crlf_frame_receiver_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    err_count++;
  endtask

  function automatic void decode_rx_byte(input logic [BYTE_W-1:0] b);
    int n;
    frame_word_t w;
    case (rx_state)
      ST_RECV: begin
        if (b == CH_CR) begin
          rx_state = ST_WAIT_LF;
        end else begin
          if (rx_count < MAX_PAYLOAD) payload_mem[rx_count] = b;
          rx_count = (b == CH_START) ? '0 : rx_count + 1'b1;
          if (rx_count > MAX_PAYLOAD || b == CH_LF) rx_state = ST_IDLE;
        end
      end
      ST_WAIT_LF: begin
        if (b == CH_START) begin
          rx_count = '0;
          rx_state = ST_RECV;
        end else begin
          if (b == CH_LF) begin
            n = (rx_count > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(rx_count);
            if (n == 0) begin
              w = '0;
              w.last = 1'b1;
              frame_words_due.push_back(w);
            end
            for (int k = 0; k < n; k++) begin
              w.frame_byte = payload_mem[k];
              w.byte_pos   = POS_W'(k);
              w.frame_len  = LEN_W'(n);
              w.last       = (k + 1 == n);
              frame_words_due.push_back(w);
            end
          end
          rx_state = ST_IDLE;
        end
      end
      default: begin
        if (b == CH_START) begin
          rx_count = '0;
          rx_state = ST_RECV;
        end else begin
          rx_state = ST_IDLE;
        end
      end
    endcase
  endfunction

  // Receiver: stall on a rotating pattern, or hold off while hold_cycles runs down.
  initial begin
    out_tready = 1'b0;
    ready_pat  = 8'hFF;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else begin
        if ($urandom_range(0, 31) == 0)
          ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        out_tready <= ready_pat[0];
        ready_pat = {ready_pat[0], ready_pat[7:1]};
      end
    end
  end

  always @(posedge clk) begin
    frame_word_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_words_due.size() == 0) begin
        report_mismatch($sformatf("word with none due: data=%h last=%b", out_tdata, out_tlast));
      end else begin
        exp_w = frame_words_due.pop_front();
        if (out_tdata[BYTE_W-1:0] !== exp_w.frame_byte)
          report_mismatch($sformatf("frame_byte %h, want %h",
                                    out_tdata[BYTE_W-1:0], exp_w.frame_byte));
        if (out_tdata[LEN_LO-1:POS_LO] !== exp_w.byte_pos)
          report_mismatch($sformatf("byte_position %0d, want %0d",
                                    out_tdata[LEN_LO-1:POS_LO], exp_w.byte_pos));
        if (out_tdata[PAD_LO-1:LEN_LO] !== exp_w.frame_len)
          report_mismatch($sformatf("frame_length %0d, want %0d",
                                    out_tdata[PAD_LO-1:LEN_LO], exp_w.frame_len));
        if (out_tlast !== exp_w.last)
          report_mismatch($sformatf("tlast %b, want %b", out_tlast, exp_w.last));
        if (out_tdata[OUT_DATA_W-1:PAD_LO] !== '0)
          report_mismatch($sformatf("padding bits %b", out_tdata[OUT_DATA_W-1:PAD_LO]));
      end
    end
  end

  task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_rx_byte(b);
    burst_left--;
    rx_items++;
    @(negedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] rand_payload_byte();
    logic [BYTE_W-1:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_START || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  task automatic send_frame(input int len);
    send_rx_byte(CH_START);
    repeat (len) send_rx_byte(rand_payload_byte());
    send_rx_byte(CH_CR);
    send_rx_byte(CH_LF);
  endtask

  // Drain: drop valid, wait for every due word, then keep watching for strays.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk);
    repeat (MAX_PAYLOAD + 6) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_directed_frames();
    logic [BYTE_W-1:0] edge_bytes [MAX_PAYLOAD] =
      '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h7F, 8'h80, 8'h01, 8'hFE};
    send_rx_byte(CH_LF);
    send_rx_byte(CH_START);
    send_rx_byte(CH_CR);
    send_rx_byte(CH_LF);
    send_rx_byte(CH_START);
    foreach (edge_bytes[i]) send_rx_byte(edge_bytes[i]);
    send_rx_byte(CH_CR);
    send_rx_byte(CH_LF);
    settle();
  endtask

  task automatic test_special_cases();
    send_rx_byte(CH_START);
    send_rx_byte("a");
    send_rx_byte(CH_START);
    send_rx_byte("b");
    send_rx_byte(CH_CR);
    send_rx_byte(CH_LF);
    send_rx_byte(CH_START);
    send_rx_byte(CH_LF);
    send_rx_byte(CH_START);
    send_rx_byte(CH_CR);
    send_rx_byte(CH_START);
    send_rx_byte("c");
    send_rx_byte(CH_CR);
    send_rx_byte("z");
    send_rx_byte(CH_START);
    repeat (MAX_PAYLOAD + 1) send_rx_byte(rand_payload_byte());
    send_rx_byte(CH_CR);
    send_rx_byte(CH_LF);
    settle();
  endtask

  task automatic test_input_backpressure();
    gap_max     = 0;
    burst_left  = 0;
    hold_cycles = 200;
    repeat (6) send_frame(MAX_PAYLOAD);
    settle();
    gap_max = 6;
  endtask

  task automatic test_random_traffic();
    while (rx_items < 320) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: send_frame($urandom_range(0, MAX_PAYLOAD));
        6: begin
          send_rx_byte(CH_START);
          repeat (MAX_PAYLOAD + 1) send_rx_byte(rand_payload_byte());
          if ($urandom_range(0, 1) == 0) begin
            send_rx_byte(CH_CR);
            send_rx_byte(CH_LF);
          end
        end
        7, 8: begin
          send_rx_byte(CH_START);
          repeat ($urandom_range(0, MAX_PAYLOAD)) send_rx_byte(rand_payload_byte());
          case ($urandom_range(0, 3))
            0: send_rx_byte(CH_LF);
            1: begin
              send_rx_byte(CH_CR);
              send_rx_byte(8'($urandom_range(0, 255)));
            end
            2: begin
              send_rx_byte(CH_CR);
              send_frame($urandom_range(0, MAX_PAYLOAD) - 1 + 1);
            end
            default: send_rx_byte(8'($urandom_range(0, 255)));
          endcase
        end
        default: begin
          repeat ($urandom_range(1, 4)) begin
            send_rx_byte(8'($urandom_range(0, 255)));
          end
        end
      endcase
    end
    settle();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    rx_state  = ST_IDLE;
    rx_count  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_frames();
    test_special_cases();
    test_input_backpressure();
    test_random_traffic();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
